@@ sv/lpmr_pkg.sv @@
// Shared types and constants for the length-prefixed message ring.
`timescale 1ns / 1ps
package lpmr_pkg;

   localparam int RING_BYTES   = 4096;
   localparam int PREFIX_BYTES = 8;
   localparam int PTR_W        = $clog2(RING_BYTES);
   localparam int CNT_W        = PTR_W + 1;
   localparam int IDX_W        = 4;
   localparam int BSEL_W       = 3;
   localparam int LEN_W        = 8 * PREFIX_BYTES;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_PREFIX = 5'b00010,
      S_HDR    = 5'b00100,
      S_LEN    = 5'b01000,
      S_BODY   = 5'b10000
   } state_type;

   typedef struct packed {
      logic take;
      logic prefix_wr;
      logic hdr_rd;
      logic len_ld;
      logic body_out;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic start_prefix;
      logic start_hdr;
      logic start_body;
      logic prefix_done;
      logic hdr_done;
   } stat_type;

endpackage

@@ sv/lpmr_if.sv @@
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface lpmr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, operation, data_byte, end_of_message, input ready);
   modport sink (input valid, operation, data_byte, end_of_message, output ready);
endinterface

interface lpmr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       message_end;
   logic [1:0] status;

   modport source (output valid, read_byte, message_end, status, input ready);
   modport sink (input valid, read_byte, message_end, status, output ready);
endinterface

@@ sv/length_prefixed_message_ring.sv @@
// Top level of the length-prefixed message ring.
`timescale 1ns / 1ps
// A 4096-byte ring stores whole messages, each an 8-byte little-endian length
// followed by its body. Every request word answers exactly one response word.
// Peeks, non-final pushes, rejected final pushes and empty pops are answered
// from the idle state. A committed final push answers at once, then writes the
// length prefix through the single RAM write port before the next word is taken.
// A pop inside a message goes on to the body state (registered RAM read); the
// first pop of a message steps through the accept, 8 prefix reads, the wait for
// the last read data, the length load and the body read. A new request is taken
// only while the response register is empty or being drained in the same cycle.
module length_prefixed_message_ring import lpmr_pkg::*; (
   input logic        clock,
   input logic        reset,
   lpmr_req_if.sink   req_chan,
   lpmr_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   lpmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpmr_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_chan.operation),
      .req_data_byte      (req_chan.data_byte),
      .req_end_of_message (req_chan.end_of_message),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_read_byte      (rsp_chan.read_byte),
      .rsp_message_end    (rsp_chan.message_end),
      .rsp_status         (rsp_chan.status)
   );

endmodule

@@ sv/lpmr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lpmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lpmr_ctrl.sv @@
// Controller state machine: sequences prefix writes, header reads and body pops.
`timescale 1ns / 1ps
module lpmr_ctrl import lpmr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = stat.slot_free;
            cmd.take  = req_valid && stat.slot_free;
            if (cmd.take) begin
               priority if (stat.start_prefix) begin
                  state_in = S_PREFIX;
               end else if (stat.start_hdr) begin
                  state_in = S_HDR;
               end else if (stat.start_body) begin
                  state_in = S_BODY;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PREFIX: begin
            cmd.prefix_wr = 1'b1;
            if (stat.prefix_done) begin
               state_in = S_IDLE;
            end
         end
         S_HDR: begin
            cmd.hdr_rd = 1'b1;
            if (stat.hdr_done) begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            cmd.len_ld = 1'b1;
            state_in   = S_BODY;
         end
         S_BODY: begin
            cmd.body_out = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/lpmr_dp.sv @@
// Datapath: pointers, push and pop bookkeeping, ring memory and response word.
`timescale 1ns / 1ps
module lpmr_dp import lpmr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_message_end,
   output logic [1:0] rsp_status
);

   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in, cursor_ff, cursor_in;
   logic [CNT_W-1:0] count_ff, count_in, remain_ff, remain_in, plen_ff, plen_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      lo_ff, lo_in;
   logic             hinz_ff, hinz_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             mend_ff, mend_in;
   logic [1:0]       status_ff, status_in;

   logic             wr_en;
   logic [PTR_W-1:0] wr_addr, rd_addr;
   logic [7:0]       wr_data, rd_data;

   logic [PTR_W-1:0] used, usedm8;
   logic [CNT_W-1:0] free_bytes, eff_len;
   logic             store_ok, is_push, is_pop, pop_idle, is_last;
   logic [LEN_W-1:0] plen_wide;
   logic [BSEL_W-1:0] cap_sel;

   lpmr_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign used       = wp_ff - rp_ff;
   assign usedm8     = used - PTR_W'(PREFIX_BYTES);
   assign free_bytes = CNT_W'(RING_BYTES) - {1'b0, used};
   assign store_ok   = !ovf_ff &&
                       (({1'b0, count_ff} + (CNT_W+1)'(PREFIX_BYTES + 1)) < {1'b0, free_bytes});
   assign is_push    = (req_operation == OP_PUSH);
   assign is_pop     = (req_operation == OP_POP);
   assign is_last    = req_end_of_message;
   assign pop_idle   = (remain_ff == '0);
   assign plen_wide  = LEN_W'(plen_ff);
   assign cap_sel    = BSEL_W'(idx_ff - IDX_W'(1));

   always_comb begin
      if (hinz_ff || (lo_ff > 16'(usedm8))) begin
         eff_len = {1'b0, usedm8};
      end else if (lo_ff == '0) begin
         eff_len = CNT_W'(1);
      end else begin
         eff_len = lo_ff[CNT_W-1:0];
      end
   end

   always_comb begin
      stat.slot_free    = !rsp_valid_ff || rsp_ready;
      stat.start_prefix = is_push && is_last && store_ok;
      stat.start_body   = is_pop && !pop_idle;
      stat.start_hdr    = is_pop && pop_idle && (used > PTR_W'(PREFIX_BYTES));
      stat.prefix_done  = (idx_ff == IDX_W'(PREFIX_BYTES - 1));
      stat.hdr_done     = (idx_ff == IDX_W'(PREFIX_BYTES));
   end

   always_comb begin
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      cursor_in    = cursor_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      plen_in      = plen_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hinz_in      = hinz_ff;
      byte_in      = byte_ff;
      mend_in      = mend_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = wp_ff + PTR_W'(PREFIX_BYTES) + PTR_W'(count_ff);
      wr_data      = req_data_byte;
      rd_addr      = cursor_ff;

      if (cmd.take) begin
         idx_in  = '0;
         lo_in   = '0;
         hinz_in = 1'b0;
         if (is_push) begin
            rsp_valid_in = 1'b1;
            byte_in      = '0;
            mend_in      = 1'b0;
            status_in    = STAT_OK;
            if (store_ok) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            if (is_last) begin
               plen_in   = count_ff + CNT_W'(1);
               count_in  = '0;
               ovf_in    = 1'b0;
               status_in = store_ok ? STAT_OK : STAT_FULL;
            end
         end else if (is_pop) begin
            if (pop_idle && !(used > PTR_W'(PREFIX_BYTES))) begin
               rsp_valid_in = 1'b1;
               byte_in      = '0;
               mend_in      = 1'b0;
               status_in    = STAT_EMPTY;
               rp_in        = wp_ff;
            end
         end else begin
            rsp_valid_in = 1'b1;
            byte_in      = '0;
            mend_in      = 1'b0;
            status_in    = (wp_ff != rp_ff) ? STAT_OK : STAT_EMPTY;
         end
      end

      if (cmd.prefix_wr) begin
         wr_en   = 1'b1;
         wr_addr = wp_ff + PTR_W'(idx_ff);
         wr_data = plen_wide[8*idx_ff[BSEL_W-1:0] +: 8];
         idx_in  = idx_ff + IDX_W'(1);
         if (stat.prefix_done) begin
            wp_in = wp_ff + PTR_W'(PREFIX_BYTES) + PTR_W'(plen_ff);
         end
      end

      if (cmd.hdr_rd) begin
         rd_addr = rp_ff + PTR_W'(idx_ff);
         idx_in  = idx_ff + IDX_W'(1);
         if (idx_ff != '0) begin
            priority if (cap_sel == BSEL_W'(0)) begin
               lo_in[7:0] = rd_data;
            end else if (cap_sel == BSEL_W'(1)) begin
               lo_in[15:8] = rd_data;
            end else begin
               hinz_in = hinz_ff || (rd_data != '0);
            end
         end
      end

      if (cmd.len_ld) begin
         remain_in = eff_len;
         cursor_in = rp_ff + PTR_W'(PREFIX_BYTES);
         rd_addr   = rp_ff + PTR_W'(PREFIX_BYTES);
      end

      if (cmd.body_out) begin
         rsp_valid_in = 1'b1;
         byte_in      = rd_data;
         mend_in      = (remain_ff == CNT_W'(1));
         status_in    = STAT_OK;
         cursor_in    = cursor_ff + PTR_W'(1);
         remain_in    = remain_ff - CNT_W'(1);
         if (remain_ff == CNT_W'(1)) begin
            rp_in = cursor_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         cursor_ff    <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plen_ff   <= plen_in;
      lo_ff     <= lo_in;
      hinz_ff   <= hinz_in;
      byte_ff   <= byte_in;
      mend_ff   <= mend_in;
      status_ff <= status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_byte   = byte_ff;
   assign rsp_message_end = mend_ff;
   assign rsp_status      = status_ff;

endmodule

@@ test/tb_length_prefixed_message_ring.sv @@
// Testbench for the length-prefixed message ring: directed and random words, every reply checked.
`timescale 1ns / 1ps
module tb_length_prefixed_message_ring;
   import lpmr_pkg::*;

   localparam logic [1:0] OP_SPARE     = 2'd3;   // unused code, answers like a peek
   localparam int         IDLE_LIMIT   = 2000;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         RANDOM_WORDS = 1900;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       message_end;
      logic [1:0] status;
   } ring_reply_type;

   class ring_scoreboard;
      bit [7:0]       ring_mem [RING_BYTES];
      int unsigned    wr_ptr, rd_ptr, body_len, pop_left, pop_pos;
      bit             dropping;
      ring_reply_type awaited [$];
      int             errors, commits, full_msgs, empty_replies, msg_ends, wraps;

      function int unsigned fill_level();
         return (wr_ptr + RING_BYTES - rd_ptr) % RING_BYTES;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function ring_reply_type note_request(logic [1:0] op, logic [7:0] b, logic e);
         ring_reply_type  r;
         int unsigned     room, u;
         longint unsigned len;
         int              i;
         r = '0;
         case (op)
            OP_PUSH: begin
               room = RING_BYTES - fill_level();
               if (!dropping && PREFIX_BYTES + body_len + 1 < room) begin
                  ring_mem[(wr_ptr + PREFIX_BYTES + body_len) % RING_BYTES] = b;
                  body_len++;
               end else begin
                  dropping = 1'b1;
               end
               if (e) begin
                  if (!dropping && PREFIX_BYTES + body_len < room) begin
                     len = body_len;
                     for (i = 0; i < PREFIX_BYTES; i++)
                        ring_mem[(wr_ptr + i) % RING_BYTES] = len[8*i +: 8];
                     if (wr_ptr + PREFIX_BYTES + body_len >= RING_BYTES) wraps++;
                     wr_ptr = (wr_ptr + PREFIX_BYTES + body_len) % RING_BYTES;
                     commits++;
                  end else begin
                     r.status = STAT_FULL;
                     full_msgs++;
                  end
                  body_len = 0;
                  dropping = 1'b0;
               end
            end
            OP_POP: begin
               u = fill_level();
               if (pop_left == 0 && u <= PREFIX_BYTES) begin
                  // a stub no longer than a prefix is thrown away
                  rd_ptr   = wr_ptr;
                  r.status = STAT_EMPTY;
               end else begin
                  if (pop_left == 0) begin
                     len = 0;
                     for (i = 0; i < PREFIX_BYTES; i++)
                        len[8*i +: 8] = ring_mem[(rd_ptr + i) % RING_BYTES];
                     if (len == 0) len = 1;
                     if (len > u - PREFIX_BYTES) len = u - PREFIX_BYTES;
                     pop_left = len[31:0];
                     pop_pos  = (rd_ptr + PREFIX_BYTES) % RING_BYTES;
                  end
                  r.read_byte = ring_mem[pop_pos];
                  pop_pos     = (pop_pos + 1) % RING_BYTES;
                  pop_left--;
                  if (pop_left == 0) begin
                     r.message_end = 1'b1;
                     rd_ptr        = pop_pos;
                  end
               end
            end
            default: r.status = (wr_ptr != rd_ptr) ? STAT_OK : STAT_EMPTY;
         endcase
         if (r.status == STAT_EMPTY) empty_replies++;
         if (r.message_end) msg_ends++;
         awaited.push_back(r);
         return r;
      endfunction

      function int field_diff(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1;
         end
         return 0;
      endfunction

      function void check_response(ring_reply_type got);
         ring_reply_type want;
         if (awaited.size() == 0) begin
            $display("%0t: reply with none awaited, expected nothing, actual %0h/%0b/%0h",
                     $time, got.read_byte, got.message_end, got.status);
            errors++;
         end else begin
            want = awaited.pop_front();
            errors += field_diff("read_byte", want.read_byte, got.read_byte);
            errors += field_diff("message_end", {7'd0, want.message_end},
                                 {7'd0, got.message_end});
            errors += field_diff("status", {6'd0, want.status}, {6'd0, got.status});
         end
      endfunction
   endclass

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   lpmr_req_if     req_chan ();
   lpmr_rsp_if     rsp_chan ();
   ring_scoreboard sb = new();
   int             words_in, words_out, send_calm, idle_cycles;

   length_prefixed_message_ring DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, and now and then a calm stretch
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(50, 300);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(input logic [1:0] op, input logic [7:0] b, input logic e,
                            output ring_reply_type exp);
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.operation      <= op;
      req_chan.data_byte      <= b;
      req_chan.end_of_message <= e;
      do @(posedge clock); while (!req_chan.ready);
      exp = sb.note_request(op, b, e);
      words_in++;
   endtask

   task automatic push_message(input int len, input bit mix);
      ring_reply_type exp;
      int             i;
      for (i = 1; i <= len; i++) begin
         if (mix && $urandom_range(0, 9) == 0)
            send_word($urandom_range(0, 1) ? OP_POP : OP_PEEK, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), exp);
         send_word(OP_PUSH, 8'($urandom_range(0, 255)), i == len, exp);
      end
   endtask

   task automatic pop_message();
      ring_reply_type exp;
      do send_word(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), exp);
      while (!exp.message_end && exp.status != STAT_EMPTY);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // reply side: random stalls plus two long hold-offs that back the ring up
   initial begin
      ring_reply_type got;
      int             hold, calm, gap, next_hold_at;
      hold         = 0;
      calm         = 0;
      next_hold_at = 150;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.read_byte   = rsp_chan.read_byte;
            got.message_end = rsp_chan.message_end;
            got.status      = rsp_chan.status;
            sb.check_response(got);
            words_out++;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else if (words_out >= next_hold_at) begin
            hold         = 400;
            next_hold_at = (next_hold_at == 150) ? 4000 : 32'h7fff_ffff;
            rsp_chan.ready <= 1'b0;
         end else begin
            gap = pick_gap(calm);
            if (gap > 0) begin
               hold = gap - 1;
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      ring_reply_type exp;
      int             target, halfway, goal, r, r2, len;
      bit             paused;
      req_chan.valid          <= 1'b0;
      req_chan.operation      <= OP_PEEK;
      req_chan.data_byte      <= 8'h00;
      req_chan.end_of_message <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty ring: peek, spare code, pop
      send_word(OP_PEEK, 8'h00, 1'b0, exp);
      send_word(OP_SPARE, 8'hFF, 1'b1, exp);
      send_word(OP_POP, 8'hFF, 1'b1, exp);
      // two messages with extreme bytes, then read them back
      send_word(OP_PUSH, 8'h00, 1'b0, exp);
      send_word(OP_PUSH, 8'hFF, 1'b1, exp);
      send_word(OP_PUSH, 8'hA5, 1'b1, exp);
      send_word(OP_PEEK, 8'hFF, 1'b1, exp);
      send_word(OP_SPARE, 8'h00, 1'b0, exp);
      send_word(OP_POP, 8'h00, 1'b0, exp);
      send_word(OP_POP, 8'h00, 1'b0, exp);
      send_word(OP_POP, 8'h00, 1'b0, exp);
      send_word(OP_POP, 8'h00, 1'b0, exp);
      send_word(OP_PEEK, 8'h00, 1'b0, exp);
      // pop and peek while a message is half pushed
      send_word(OP_PUSH, 8'h5A, 1'b0, exp);
      send_word(OP_POP, 8'h00, 1'b0, exp);
      send_word(OP_PEEK, 8'h00, 1'b0, exp);
      send_word(OP_PUSH, 8'hC3, 1'b1, exp);
      send_word(OP_PEEK, 8'h00, 1'b0, exp);
      send_word(OP_POP, 8'h00, 1'b0, exp);
      send_word(OP_POP, 8'h00, 1'b1, exp);
      wait_drained();

      target  = words_in + RANDOM_WORDS;
      halfway = words_in + RANDOM_WORDS / 2;
      paused  = 1'b0;
      while (words_in < target) begin
         if (!paused && words_in >= halfway) begin
            paused = 1'b1;
            wait_drained();
         end
         r = $urandom_range(0, 99);
         if (r < 40) begin
            r2  = $urandom_range(0, 99);
            len = (r2 < 85) ? $urandom_range(1, 16) :
                  (r2 < 97) ? $urandom_range(17, 120) : $urandom_range(200, 500);
            push_message(len, 1'b1);
         end else if (r < 80) begin
            repeat ($urandom_range(1, 30))
               send_word(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), exp);
         end else if (r < 90) begin
            pop_message();
         end else begin
            send_word((r < 97) ? OP_PEEK : OP_SPARE, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), exp);
         end
      end

      // fill the ring until a message is refused, then churn at the brim
      wait_drained();
      goal = sb.full_msgs + 1;
      while (sb.full_msgs < goal) push_message($urandom_range(100, 400), 1'b0);
      repeat (2) begin
         goal = sb.full_msgs + 2;
         pop_message();
         while (sb.full_msgs < goal) push_message($urandom_range(1, 24), 1'b0);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d words, checked %0d replies: %0d messages stored, %0d refused as full.",
               words_in, words_out, sb.commits, sb.full_msgs);
      $display("Saw %0d empty replies and %0d message ends; write side wrapped %0d times.",
               sb.empty_replies, sb.msg_ends, sb.wraps);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

@@ files.f @@
sv/lpmr_pkg.sv
sv/lpmr_if.sv
sv/lpmr_ram.sv
sv/lpmr_ctrl.sv
sv/lpmr_dp.sv
sv/length_prefixed_message_ring.sv
test/tb_length_prefixed_message_ring.sv
